/* hdl/fpa_pkg.sv */
// Shared types, codes and helpers of the fit-policy allocator.
`default_nettype none
package fpa_pkg;

  // Payload field widths
  localparam int TAG_W  = 8;
  localparam int SIZE_W = 7;
  localparam int ADDR_W = 7;
  localparam int POL_W  = 2;
  localparam int NEED_W = 8;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Fit policy codes; the unused code behaves as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch request, clear scan state
    logic scan;     // issue next tag read of the scan
    logic wr_step;  // write or clear one unit
    logic finish;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic too_big;    // rounded size exceeds the largest grant
    logic scan_done;  // end-of-store position evaluated this cycle
    logic found;      // a suitable run has been picked
    logic wr_done;    // no more units to write
  } sts_t;

  // Round a size up to a power of two, at least 2
  function automatic logic [NEED_W-1:0] pow2_ceil(input logic [SIZE_W-1:0] size);
    logic [NEED_W-1:0] r;
    r = NEED_W'(2);
    for (int i = 1; i < SIZE_W; i++) begin
      if (r < NEED_W'(size)) begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/fit_policy_allocator.sv */
// Top level of the fit-policy allocator: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid/in_ready   | req_type, owner_tag, req_size, free_addr
//  out_    | result    | out_valid/out_ready | status, grant_addr, grant_size
//  cfg_    | config    | cfg_we              | fit_policy (cfg_wdata)
//
// One request at a time; an allocate scans the store at one unit per cycle, then
// writes its rounded size at one unit per cycle, or ends after the scan when no
// run fits. A free skips the scan and clears its units. An oversized allocate
// fails without a scan. Reset (rst_n low, synchronous) marks every unit free at
// once. A waiting result does not block the next request; a finished request
// holds until the result register is free.
`default_nettype none
module fit_policy_allocator #(
  parameter int MEM_UNITS = 128,
  parameter int MAX_GRANT = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fpa_pkg::POL_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic [fpa_pkg::TAG_W-1:0]   in_owner_tag,
  input  wire logic [fpa_pkg::SIZE_W-1:0]  in_req_size,
  input  wire logic [fpa_pkg::ADDR_W-1:0]  in_free_addr,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [fpa_pkg::ADDR_W-1:0]       out_grant_addr,
  output logic [fpa_pkg::SIZE_W-1:0]       out_grant_size
);

  fpa_pkg::cmd_t cmd;
  fpa_pkg::sts_t sts;

  fpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  fpa_dpath #(
    .MEM_UNITS (MEM_UNITS),
    .MAX_GRANT (MAX_GRANT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_owner_tag   (in_owner_tag),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .out_status     (out_status),
    .out_grant_addr (out_grant_addr),
    .out_grant_size (out_grant_size)
  );

endmodule
`default_nettype wire

/* hdl/fpa_ctrl.sv */
// Controller: request sequencing through scan, write and result phases.
`default_nettype none
module fpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_req_type,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fpa_pkg::cmd_t      cmd,
  input  wire fpa_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_req_type == fpa_pkg::REQ_FREE) ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.too_big) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_done) begin
            state_nxt = sts.found ? S_WRITE : S_DONE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.wr_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on finish, dropped once taken
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hdl/fpa_dpath.sv */
// Datapath: tag store, run scanner, grant/clear writer and result register.
`default_nettype none
module fpa_dpath #(
  parameter int MEM_UNITS = 128,
  parameter int MAX_GRANT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fpa_pkg::cmd_t                 cmd,
  output fpa_pkg::sts_t                      sts,
  input  wire logic                          cfg_we,
  input  wire logic [fpa_pkg::POL_W-1:0]     cfg_wdata,
  input  wire logic                          in_req_type,
  input  wire logic [fpa_pkg::TAG_W-1:0]     in_owner_tag,
  input  wire logic [fpa_pkg::SIZE_W-1:0]    in_req_size,
  input  wire logic [fpa_pkg::ADDR_W-1:0]    in_free_addr,
  output logic                               out_status,
  output logic [fpa_pkg::ADDR_W-1:0]         out_grant_addr,
  output logic [fpa_pkg::SIZE_W-1:0]         out_grant_size
);

  localparam int AW    = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int CNT_W = $clog2(MEM_UNITS + 1);
  localparam int LEN_W = (CNT_W > fpa_pkg::NEED_W) ? CNT_W : fpa_pkg::NEED_W;
  localparam int CUR_W = ((AW > fpa_pkg::ADDR_W) ? AW : fpa_pkg::ADDR_W) + 2;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MEM_UNITS);
  localparam logic [CUR_W-1:0] CUR_END = CUR_W'(MEM_UNITS);
  localparam logic [9:0]       MAXG    = 10'(MAX_GRANT);

  // Tag store and per-unit written flags
  logic [fpa_pkg::TAG_W-1:0] mem [MEM_UNITS];
  logic [MEM_UNITS-1:0]      used_r;

  // Config
  logic [fpa_pkg::POL_W-1:0] fit_policy_r;

  // Latched request
  logic                        req_free_r;
  logic [fpa_pkg::TAG_W-1:0]   tag_r;
  logic [fpa_pkg::ADDR_W-1:0]  free_addr_r;
  logic [fpa_pkg::NEED_W-1:0]  need_r;
  logic [fpa_pkg::NEED_W-1:0]  limit_r;

  // Scan state
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        scan_fin_r, scan_fin_nxt;
  logic                        rd_live_r, rd_live_nxt;
  logic                        rd_end_r, rd_end_nxt;
  logic [AW-1:0]               rd_pos_r;
  logic [fpa_pkg::TAG_W-1:0]   tag_rd_r;
  logic                        used_rd_r;
  logic [CNT_W-1:0]            run_len_r, run_len_nxt;
  logic [AW-1:0]               run_start_r, run_start_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               best_start_r, best_start_nxt;
  logic [CNT_W-1:0]            best_len_r, best_len_nxt;

  // Write state
  logic [CUR_W-1:0]            cursor_r, cursor_nxt;
  logic [fpa_pkg::NEED_W-1:0]  k_r, k_nxt;

  logic                        issue;
  logic                        is_free;
  logic                        fits;
  logic                        take;
  logic                        wr_more;
  logic                        wr_go;
  logic [fpa_pkg::NEED_W-1:0]  need_in;
  logic [AW-1:0]               rd_idx;
  logic [AW-1:0]               wr_idx;

  assign need_in = fpa_pkg::pow2_ceil(in_req_size);
  assign issue   = cmd.scan && !scan_fin_r;
  assign rd_idx  = cnt_r[AW-1:0];
  assign wr_idx  = cursor_r[AW-1:0];

  // Run evaluation of the unit whose tag was read last cycle
  assign is_free = !rd_end_r && (!used_rd_r || (tag_rd_r == '0));
  assign fits    = (LEN_W'(run_len_r) >= LEN_W'(need_r)) && (run_len_r != '0);

  always_comb begin
    if (!found_r) begin
      take = 1'b1;
    end else begin
      case (fit_policy_r)
        fpa_pkg::POL_BEST:  take = run_len_r < best_len_r;
        fpa_pkg::POL_WORST: take = run_len_r > best_len_r;
        default:            take = 1'b0;
      endcase
    end
  end

  always_comb begin
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    found_nxt      = found_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    if (rd_live_r) begin
      if (is_free) begin
        if (run_len_r == '0) begin
          run_start_nxt = rd_pos_r;
        end
        run_len_nxt = run_len_r + CNT_W'(1);
      end else begin
        if (fits && take) begin
          found_nxt      = 1'b1;
          best_start_nxt = run_start_r;
          best_len_nxt   = run_len_r;
        end
        run_len_nxt = '0;
      end
    end
  end

  // Scan read issue; the end-of-store position is a sentinel, not a read
  always_comb begin
    cnt_nxt      = cnt_r;
    scan_fin_nxt = scan_fin_r;
    rd_live_nxt  = issue;
    rd_end_nxt   = rd_end_r;
    if (issue) begin
      rd_end_nxt = (cnt_r == CNT_END);
      if (cnt_r == CNT_END) begin
        scan_fin_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Write cursor
  assign wr_more = (k_r < limit_r) && (cursor_r < CUR_END);
  assign wr_go   = cmd.wr_step && wr_more;

  always_comb begin
    cursor_nxt = cursor_r;
    k_nxt      = k_r;
    if (cmd.load) begin
      cursor_nxt = CUR_W'(in_free_addr);
      k_nxt      = '0;
    end else if (sts.scan_done) begin
      cursor_nxt = CUR_W'(best_start_nxt);
      k_nxt      = '0;
    end else if (wr_go) begin
      cursor_nxt = cursor_r + CUR_W'(1);
      k_nxt      = k_r + fpa_pkg::NEED_W'(1);
    end
  end

  // Status to the controller
  always_comb begin
    sts.too_big   = {2'b00, need_r} > MAXG;
    sts.scan_done = rd_live_r && rd_end_r;
    sts.found     = found_nxt;
    sts.wr_done   = !wr_more;
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= fpa_pkg::POL_FIRST;
    end else if (cfg_we) begin
      fit_policy_r <= cfg_wdata;
    end
  end

  // Written flags: reset marks all units free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_go) begin
      used_r[wr_idx] <= !req_free_r;
    end
  end

  // Tag store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_go && !req_free_r) begin
      mem[wr_idx] <= tag_r;
    end
    if (issue) begin
      tag_rd_r  <= mem[rd_idx];
      used_rd_r <= used_r[rd_idx];
      rd_pos_r  <= rd_idx;
    end
  end

  // Scan and request control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r  <= 1'b0;
      scan_fin_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.load) begin
      rd_live_r  <= 1'b0;
      scan_fin_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_live_r  <= rd_live_nxt;
      scan_fin_r <= scan_fin_nxt;
      found_r    <= found_nxt;
    end
  end

  // Scan and request payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free_r  <= in_req_type;
      tag_r       <= in_owner_tag;
      free_addr_r <= in_free_addr;
      need_r      <= need_in;
      limit_r     <= (in_req_type == fpa_pkg::REQ_FREE) ?
                     fpa_pkg::NEED_W'(in_req_size) : need_in;
      cnt_r       <= '0;
      rd_end_r    <= 1'b0;
      run_len_r   <= '0;
      run_start_r <= '0;
      best_start_r <= '0;
      best_len_r  <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_end_r    <= rd_end_nxt;
      run_len_r   <= run_len_nxt;
      run_start_r <= run_start_nxt;
      best_start_r <= best_start_nxt;
      best_len_r  <= best_len_nxt;
    end
    cursor_r <= cursor_nxt;
    k_r      <= k_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (req_free_r == fpa_pkg::REQ_FREE) begin
        out_status     <= fpa_pkg::ST_OK;
        out_grant_addr <= free_addr_r;
        out_grant_size <= k_r[fpa_pkg::SIZE_W-1:0];
      end else if (found_r) begin
        out_status     <= fpa_pkg::ST_OK;
        out_grant_addr <= fpa_pkg::ADDR_W'(best_start_r);
        out_grant_size <= need_r[fpa_pkg::SIZE_W-1:0];
      end else begin
        out_status     <= fpa_pkg::ST_FAIL;
        out_grant_addr <= '0;
        out_grant_size <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/fpa_checker.sv */
// Port-level checks of the fit-policy allocator, bound to the top level.
`default_nettype none
module fpa_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_status,
  input wire logic [fpa_pkg::ADDR_W-1:0]  out_grant_addr,
  input wire logic [fpa_pkg::SIZE_W-1:0]  out_grant_size
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_grant_addr) && $stable(out_grant_size))
    else $error("result changed while stalled");

  // A failed allocate reports zero address and size
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fpa_pkg::ST_FAIL) |->
    (out_grant_addr == '0) && (out_grant_size == '0))
    else $error("failed request with nonzero grant");

  // One request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  // Reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fit_policy_allocator fpa_checker u_fpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_grant_addr (out_grant_addr),
  .out_grant_size (out_grant_size)
);
`default_nettype wire

/* tb/fit_policy_allocator_checker.sv */
// Checker for the fit-policy allocator: tracks the unit store, predicts each grant, compares.
`timescale 1ns / 1ps
module fit_policy_allocator_checker #(
  parameter int MEM_UNITS = 128,
  parameter int MAX_GRANT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [fpa_pkg::POL_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [fpa_pkg::TAG_W-1:0]  in_owner_tag,
  input  logic [fpa_pkg::SIZE_W-1:0] in_req_size,
  input  logic [fpa_pkg::ADDR_W-1:0] in_free_addr,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_status,
  input  logic [fpa_pkg::ADDR_W-1:0] out_grant_addr,
  input  logic [fpa_pkg::SIZE_W-1:0] out_grant_size,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic                       req_type;
    logic [fpa_pkg::TAG_W-1:0]  owner_tag;
    logic [fpa_pkg::SIZE_W-1:0] req_size;
    logic [fpa_pkg::ADDR_W-1:0] free_addr;
  } request_t;

  typedef struct packed {
    logic                       status;
    logic [fpa_pkg::ADDR_W-1:0] grant_addr;
    logic [fpa_pkg::SIZE_W-1:0] grant_size;
  } grant_t;

  // Mirror of the unit store and the fit policy
  logic [fpa_pkg::TAG_W-1:0] unit_tags [MEM_UNITS];
  logic [fpa_pkg::POL_W-1:0] active_policy;
  grant_t                    awaited_grants [$];
  grant_t                    awaited;
  request_t                  accepted;
  int                        miss_total;

  // Serve one request against the mirror and return the grant it should produce
  function automatic grant_t serve_request(input request_t rq);
    grant_t g;
    int     need, run_start, run_len, pick_start, pick_len, cleared, a;
    bit     found, vacant, take;
    g = '0;
    if (rq.req_type == fpa_pkg::REQ_FREE) begin
      // Clear from the address, clipped at the end of the store
      cleared = 0;
      for (int k = 0; k < rq.req_size; k++) begin
        a = rq.free_addr + k;
        if (a >= MEM_UNITS) break;
        unit_tags[a] = '0;
        cleared++;
      end
      g.status     = fpa_pkg::ST_OK;
      g.grant_addr = rq.free_addr;
      g.grant_size = fpa_pkg::SIZE_W'(cleared);
      return g;
    end
    // Round up to a power of two, at least 2
    need = 2;
    while (need < rq.req_size && need <= MAX_GRANT) need = need * 2;
    found      = 1'b0;
    pick_start = 0;
    pick_len   = 0;
    run_start  = 0;
    run_len    = 0;
    if (need <= MAX_GRANT) begin
      // One position past the end closes the last run
      for (int i = 0; i <= MEM_UNITS; i++) begin
        vacant = 1'b0;
        if (i < MEM_UNITS) vacant = (unit_tags[i] == '0);
        if (vacant) begin
          if (run_len == 0) run_start = i;
          run_len++;
        end else begin
          if (run_len >= need) begin
            // Ties keep the earlier run; the spare code acts as first fit
            if (!found) take = 1'b1;
            else if (active_policy == fpa_pkg::POL_BEST) take = run_len < pick_len;
            else if (active_policy == fpa_pkg::POL_WORST) take = run_len > pick_len;
            else take = 1'b0;
            if (take) begin
              found      = 1'b1;
              pick_start = run_start;
              pick_len   = run_len;
            end
          end
          run_len = 0;
        end
      end
    end
    if (!found) begin
      g.status = fpa_pkg::ST_FAIL;
      return g;
    end
    for (int k = 0; k < need && pick_start + k < MEM_UNITS; k++)
      unit_tags[pick_start + k] = rq.owner_tag;
    g.status     = fpa_pkg::ST_OK;
    g.grant_addr = fpa_pkg::ADDR_W'(pick_start);
    g.grant_size = fpa_pkg::SIZE_W'(need);
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (unit_tags[i]) unit_tags[i] = '0;
      active_policy = fpa_pkg::POL_FIRST;
      awaited_grants.delete();
    end else begin
      if (cfg_we) active_policy = cfg_wdata;
      // Results first: a result never belongs to a request accepted on the same edge
      if (out_valid && out_ready) begin
        if (awaited_grants.size() == 0) begin
          $error("result with no request waiting: status %0d grant_addr %0d grant_size %0d",
                 out_status, out_grant_addr, out_grant_size);
          miss_total++;
        end else begin
          awaited = awaited_grants.pop_front();
          if (out_status !== awaited.status) begin
            $error("status: expected %0d, got %0d", awaited.status, out_status);
            miss_total++;
          end
          if (out_grant_addr !== awaited.grant_addr) begin
            $error("grant_addr: expected %0d, got %0d", awaited.grant_addr, out_grant_addr);
            miss_total++;
          end
          if (out_grant_size !== awaited.grant_size) begin
            $error("grant_size: expected %0d, got %0d", awaited.grant_size, out_grant_size);
            miss_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        accepted = '{in_req_type, in_owner_tag, in_req_size, in_free_addr};
        awaited_grants.push_back(serve_request(accepted));
      end
    end
    mismatches  <= miss_total;
    outstanding <= awaited_grants.size();
  end

endmodule

/* tb/fit_policy_allocator_test.sv */
// Testbench top of the fit-policy allocator: request stimulus, checker hook-up and verdict.
`timescale 1ns / 1ps
module fit_policy_allocator_test;

  localparam int IDLE_LIMIT     = 5000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 105;
  // Unused policy code, expected to behave as first fit
  localparam logic [fpa_pkg::POL_W-1:0] POL_SPARE = 2'd3;

  typedef struct {
    logic [fpa_pkg::ADDR_W-1:0] addr;
    logic [fpa_pkg::SIZE_W-1:0] units;
  } block_t;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic [fpa_pkg::POL_W-1:0]  cfg_wdata      = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_req_type    = fpa_pkg::REQ_ALLOC;
  logic [fpa_pkg::TAG_W-1:0]  in_owner_tag   = '0;
  logic [fpa_pkg::SIZE_W-1:0] in_req_size    = '0;
  logic [fpa_pkg::ADDR_W-1:0] in_free_addr   = '0;
  logic                       out_ready      = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic                       out_status;
  logic [fpa_pkg::ADDR_W-1:0] out_grant_addr;
  logic [fpa_pkg::SIZE_W-1:0] out_grant_size;

  int     mismatches;
  int     outstanding;
  int     idle_cycles;
  int     ready_hold;
  logic   kind_q [$];
  block_t live_blocks [$];

  logic [fpa_pkg::POL_W-1:0] phase_policy [RANDOM_PHASES] =
    '{fpa_pkg::POL_BEST, fpa_pkg::POL_WORST, fpa_pkg::POL_FIRST, POL_SPARE,
      fpa_pkg::POL_WORST, fpa_pkg::POL_BEST, fpa_pkg::POL_FIRST, fpa_pkg::POL_WORST};

  fit_policy_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_owner_tag   (in_owner_tag),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_grant_addr (out_grant_addr),
    .out_grant_size (out_grant_size)
  );

  fit_policy_allocator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_owner_tag   (in_owner_tag),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_grant_addr (out_grant_addr),
    .out_grant_size (out_grant_size),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: ready held high or low for random stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold == 0) begin
      out_ready  <= ($urandom_range(0, 9) < 7);
      ready_hold <= $urandom_range(1, 40);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Learn granted blocks so later frees can release them; sampled mid-cycle
  always @(negedge clk) begin
    if (!rst_n) begin
      kind_q.delete();
    end else begin
      if (out_valid && out_ready && kind_q.size() != 0) begin
        if (kind_q.pop_front() == fpa_pkg::REQ_ALLOC && out_status == fpa_pkg::ST_OK)
          live_blocks.push_back('{out_grant_addr, out_grant_size});
        if (live_blocks.size() > 96) void'(live_blocks.pop_front());
      end
      if (in_valid && in_ready) kind_q.push_back(in_req_type);
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic kind, input logic [fpa_pkg::TAG_W-1:0] tag,
                              input logic [fpa_pkg::SIZE_W-1:0] units,
                              input logic [fpa_pkg::ADDR_W-1:0] addr);
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_owner_tag <= tag;
    in_req_size  <= units;
    in_free_addr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_policy(input logic [fpa_pkg::POL_W-1:0] policy);
    cfg_we    <= 1'b1;
    cfg_wdata <= policy;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random request: mostly small allocations and frees of known blocks
  task automatic random_request();
    int                         roll;
    int                         idx;
    logic [fpa_pkg::SIZE_W-1:0] units;
    logic [fpa_pkg::TAG_W-1:0]  tag;
    block_t                     victim;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) units = fpa_pkg::SIZE_W'($urandom_range(1, 16));
      else if (roll < 92) units = fpa_pkg::SIZE_W'($urandom_range(17, 64));
      else if (roll < 96) units = '0;
      else units = fpa_pkg::SIZE_W'($urandom_range(65, 127));
      tag = ($urandom_range(0, 19) == 0) ? '0 : fpa_pkg::TAG_W'($urandom_range(1, 255));
      send_request(fpa_pkg::REQ_ALLOC, tag, units,
                   fpa_pkg::ADDR_W'($urandom_range(0, 127)));
    end else if (roll < 87 && live_blocks.size() != 0) begin
      idx    = $urandom_range(0, live_blocks.size() - 1);
      victim = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(fpa_pkg::REQ_FREE, fpa_pkg::TAG_W'($urandom), victim.units, victim.addr);
    end else begin
      units = ($urandom_range(0, 4) == 0) ? fpa_pkg::SIZE_W'($urandom_range(0, 127))
                                          : fpa_pkg::SIZE_W'($urandom_range(1, 20));
      send_request(fpa_pkg::REQ_FREE, fpa_pkg::TAG_W'($urandom), units,
                   fpa_pkg::ADDR_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int hold_at;
    int burst_left;
    int gap;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first fit after reset, back to back
    send_request(fpa_pkg::REQ_ALLOC, 8'd1,   7'd0,   7'd0);    // size zero rounds to 2
    send_request(fpa_pkg::REQ_ALLOC, 8'd255, 7'd1,   7'd127);  // size one rounds to 2
    send_request(fpa_pkg::REQ_ALLOC, 8'h80,  7'd3,   7'd0);    // rounds to 4
    send_request(fpa_pkg::REQ_ALLOC, 8'h7f,  7'd64,  7'd0);    // largest grant
    send_request(fpa_pkg::REQ_ALLOC, 8'd9,   7'd65,  7'd0);    // rounds past largest grant
    send_request(fpa_pkg::REQ_ALLOC, 8'd9,   7'd127, 7'd0);
    send_request(fpa_pkg::REQ_ALLOC, 8'd9,   7'd64,  7'd0);    // no run long enough
    send_request(fpa_pkg::REQ_ALLOC, 8'd0,   7'd5,   7'd0);    // zero tag leaves units free
    send_request(fpa_pkg::REQ_FREE,  8'd0,   7'd4,   7'd4);    // opens a small hole
    send_request(fpa_pkg::REQ_FREE,  8'd0,   7'd127, 7'd120);  // clipped at the end
    send_request(fpa_pkg::REQ_FREE,  8'd0,   7'd1,   7'd127);  // last unit
    send_request(fpa_pkg::REQ_FREE,  8'd0,   7'd0,   7'd0);    // clears nothing

    // Directed: same store under each policy
    wait_idle();
    set_policy(fpa_pkg::POL_BEST);
    send_request(fpa_pkg::REQ_ALLOC, 8'd33, 7'd2, 7'd0);
    wait_idle();
    set_policy(fpa_pkg::POL_WORST);
    send_request(fpa_pkg::REQ_ALLOC, 8'd34, 7'd2, 7'd0);
    wait_idle();
    set_policy(POL_SPARE);
    send_request(fpa_pkg::REQ_ALLOC, 8'd35, 7'd2, 7'd0);
    send_request(fpa_pkg::REQ_FREE,  8'd0,  7'd127, 7'd0);     // near-full clear

    // Random phases, one policy each, sender in bursts
    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      set_policy(phase_policy[ph]);
      hold_at = $urandom_range(10, PHASE_REQUESTS - 10);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n == hold_at) wait_idle();
        random_request();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
    end

    // Drain, then allow late or stray results to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
